// ===== hdl/machine_timer_compare_interrupt_macros.svh =====
// Assertion helpers for the machine timer block.
// The module using them must have i_clk and an active-low i_rst_n.
`ifndef MACHINE_TIMER_COMPARE_INTERRUPT_MACROS_SVH
`define MACHINE_TIMER_COMPARE_INTERRUPT_MACROS_SVH

// Same-cycle implication.
`define MTCI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mtci: same-cycle check failed");

// Next-cycle implication.
`define MTCI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mtci: next-cycle check failed");

`endif

// ===== hdl/mtci_pkg.sv =====
`default_nettype none

package mtci_pkg;

    localparam int HALF_W = 32;
    localparam int CMP_W  = 64;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        SEL_TIME_LO = 2'd0,
        SEL_TIME_HI = 2'd1,
        SEL_CMP_LO  = 2'd2,
        SEL_CMP_HI  = 2'd3
    } t_sel;

    typedef enum logic [1:0] {
        CODE_NONE     = 2'd0,
        CODE_EXTERNAL = 2'd1,
        CODE_TIMER    = 2'd2
    } t_code;

    typedef struct packed {
        logic [1:0]        command;
        logic [1:0]        reg_select;
        logic [HALF_W-1:0] write_data;
        logic [HALF_W-1:0] elapsed_ticks;
        logic              ext_claim_active;
        logic              ext_pending_bit;
        logic              ext_enable_bit;
        logic              timer_enable_bit;
        logic              global_enable_bit;
    } t_item;

    typedef struct packed {
        logic [HALF_W-1:0] read_data;
        logic              timer_pending;
        logic              wake_core;
        logic [1:0]        interrupt_code;
    } t_result;

    // handshake between two internal stages
    typedef struct packed {
        logic valid;
        logic take;
    } t_flow;

endpackage

`default_nettype wire

// ===== hdl/mtci_in_stage.sv =====
`default_nettype none

module mtci_in_stage
    import mtci_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    input  wire t_item i_item,
    input  wire logic  i_take,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  load;

    assign o_stall = r_valid && !i_take;
    assign load    = i_valid && !o_stall;

    always_comb begin
        if (load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== hdl/mtci_core.sv =====
`default_nettype none

`include "machine_timer_compare_interrupt_macros.svh"

module mtci_core
    import mtci_pkg::*;
#(
    parameter int TIME_WIDTH = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_go,
    input  wire t_item i_item,
    output t_result    o_res
);

    logic [TIME_WIDTH-1:0] r_time;
    logic [TIME_WIDTH-1:0] n_time;
    logic [CMP_W-1:0]      r_compare;
    logic [CMP_W-1:0]      n_compare;
    logic                  r_pending;
    logic                  n_pending;

    logic [TIME_WIDTH-1:0] time_sum;
    logic                  ext_take;
    logic                  hit;
    logic [HALF_W-1:0]     rdata;
    logic                  wake;
    t_code                 code;

    assign ext_take = i_item.ext_claim_active && i_item.ext_pending_bit
                   && i_item.ext_enable_bit && i_item.global_enable_bit;
    assign time_sum = r_time + TIME_WIDTH'(i_item.elapsed_ticks);
    // compare of zero disables; bits above the time range make it unreachable
    assign hit      = (r_compare != '0) && (CMP_W'(time_sum) >= r_compare);

    always_comb begin
        n_time    = r_time;
        n_compare = r_compare;
        n_pending = r_pending;
        rdata     = '0;
        wake      = 1'b0;
        code      = CODE_NONE;
        unique case (i_item.command)
            CMD_TICK: begin
                if (ext_take) begin
                    code = CODE_EXTERNAL;
                end else begin
                    n_time    = time_sum;
                    n_pending = hit;
                    wake      = hit;
                    if (hit && i_item.timer_enable_bit && i_item.global_enable_bit) begin
                        code = CODE_TIMER;
                    end
                end
            end
            CMD_READ: begin
                unique case (t_sel'(i_item.reg_select))
                    SEL_TIME_LO: rdata = r_time[HALF_W-1:0];
                    SEL_TIME_HI: rdata = HALF_W'(r_time >> HALF_W);
                    SEL_CMP_LO:  rdata = r_compare[HALF_W-1:0];
                    SEL_CMP_HI:  rdata = r_compare[CMP_W-1:HALF_W];
                    default:     rdata = '0;
                endcase
            end
            CMD_WRITE: begin
                // time halves are read-only
                if (i_item.reg_select == SEL_CMP_LO) begin
                    n_compare[HALF_W-1:0] = i_item.write_data;
                end else if (i_item.reg_select == SEL_CMP_HI) begin
                    n_compare[CMP_W-1:HALF_W] = i_item.write_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time    <= '0;
            r_compare <= '0;
            r_pending <= 1'b0;
        end else if (i_go) begin
            r_time    <= n_time;
            r_compare <= n_compare;
            r_pending <= n_pending;
        end
    end

    assign o_res.read_data      = rdata;
    assign o_res.timer_pending  = n_pending;
    assign o_res.wake_core      = wake;
    assign o_res.interrupt_code = code;

    `MTCI_ASSERT_IMPL(a_wake_sets_pending, i_go && o_res.wake_core, o_res.timer_pending)
    `MTCI_ASSERT_IMPL(a_timer_code_needs_flag, i_go && code == CODE_TIMER, n_pending && wake)
    `MTCI_ASSERT_NEXT(a_pending_only_on_tick, i_go && i_item.command != CMD_TICK, r_pending == $past(r_pending))
    `MTCI_ASSERT_NEXT(a_time_only_on_tick, i_go && i_item.command != CMD_TICK, $stable(r_time))
    `MTCI_ASSERT_NEXT(a_compare_only_on_write, i_go && i_item.command != CMD_WRITE, $stable(r_compare))

endmodule

`default_nettype wire

// ===== hdl/mtci_out_stage.sv =====
`default_nettype none

module mtci_out_stage
    import mtci_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // room when empty or when the held beat leaves this edge
    assign o_free = !r_valid || !i_stall;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_stall) begin
            n_valid = r_valid;
        end else begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// ===== hdl/machine_timer_compare_interrupt.sv =====
// Machine timer with 64-bit compare, reached as 32-bit register halves.
// Input channel: i_in_valid / o_in_stall with one port per field; a beat is
//   taken at a rising edge with i_in_valid high and o_in_stall low. command
//   selects tick, register read or register write.
// Output channel: o_out_valid / i_out_stall; one result beat per input beat,
//   in order.
// Path: a beat taken into the input register is processed by the core and
//   captured in the output register once it has room, and shown from then on.
// Throughput: one beat per cycle unless the receiver stalls; the time add and
//   64-bit compare sit in one stage between the input and output registers.
// Reset (synchronous, i_rst_n low): time, compare and the pending flag clear,
//   both stage registers empty, so o_in_stall is low out of reset.
// When the receiver stalls, the output beat holds; one more beat can be taken
//   into the input register, after which o_in_stall rises until the output
//   drains.
// TIME_WIDTH (32..64) sets the width of the time counter, which wraps.
`default_nettype none

module machine_timer_compare_interrupt
    import mtci_pkg::*;
#(
    parameter int TIME_WIDTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [1:0]  i_reg_select,
    input  wire logic [31:0] i_write_data,
    input  wire logic [31:0] i_elapsed_ticks,
    input  wire logic        i_ext_claim_active,
    input  wire logic        i_ext_pending_bit,
    input  wire logic        i_ext_enable_bit,
    input  wire logic        i_timer_enable_bit,
    input  wire logic        i_global_enable_bit,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_read_data,
    output logic             o_timer_pending,
    output logic             o_wake_core,
    output logic [1:0]       o_interrupt_code
);

    t_item   in_item;
    t_item   stage_item;
    t_flow   flow;
    logic    out_free;
    t_result core_res;
    t_result out_res;

    assign in_item.command           = i_command;
    assign in_item.reg_select        = i_reg_select;
    assign in_item.write_data        = i_write_data;
    assign in_item.elapsed_ticks     = i_elapsed_ticks;
    assign in_item.ext_claim_active  = i_ext_claim_active;
    assign in_item.ext_pending_bit   = i_ext_pending_bit;
    assign in_item.ext_enable_bit    = i_ext_enable_bit;
    assign in_item.timer_enable_bit  = i_timer_enable_bit;
    assign in_item.global_enable_bit = i_global_enable_bit;

    assign flow.take = flow.valid && out_free;

    mtci_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (in_item),
        .i_take  (flow.take),
        .o_valid (flow.valid),
        .o_item  (stage_item)
    );

    mtci_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (flow.take),
        .i_item  (stage_item),
        .o_res   (core_res)
    );

    mtci_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (flow.take),
        .i_res   (core_res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (out_res)
    );

    assign o_read_data      = out_res.read_data;
    assign o_timer_pending  = out_res.timer_pending;
    assign o_wake_core      = out_res.wake_core;
    assign o_interrupt_code = out_res.interrupt_code;

endmodule

`default_nettype wire
